// File: rtl/srem_pkg.sv
// ----------------------------------------------------------------------------
// srem_pkg
// Shared constants, types and helpers of the gradient magnitude edge filter.
// ----------------------------------------------------------------------------
package srem_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int PIX_W      = 8;
    localparam int COL_W      = 11;
    localparam int ROW_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OPERATOR_SELECT = 2'd2;

    localparam logic [COL_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [ROW_W-1:0] FRAME_HEIGHT_RST = 16'd480;

    // operation codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // operator codes
    localparam logic OPSEL_SOBEL   = 1'b0;
    localparam logic OPSEL_ROBERTS = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } t_column;

    typedef struct packed {
        t_column left;
        t_column center;
        t_column right;
    } t_window;

    typedef struct packed {
        logic [PIX_W-1:0] edge_value;
        logic             row_end;
        logic             frame_end;
        logic             last_in_step;
    } t_result;

    typedef struct packed {
        logic              pixel;
        logic              drain;
        logic [ADDR_W-1:0] addr;
        logic              top_is_mid;
        logic              en_a;
        logic              en_b;
        logic              c_is1;
        logic              c_ge1;
        logic              k0;
        logic              k_last;
        logic [1:0]        cnt;
    } t_stage1;

    function automatic t_column col_fill(input logic [PIX_W-1:0] top,
                                         input logic [PIX_W-1:0] mid,
                                         input logic [PIX_W-1:0] bot,
                                         input logic             top_is_mid);
        t_column col;
        col.top = top_is_mid ? mid : top;
        col.mid = mid;
        col.bot = bot;
        return col;
    endfunction

endpackage

// File: rtl/srem_in_if.sv
// ----------------------------------------------------------------------------
// srem_in_if
// Input channel: pixel or flush transactions with valid/ready handshake.
// ----------------------------------------------------------------------------
interface srem_in_if;
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [srem_pkg::PIX_W-1:0]   pixel_value;

    modport source (output valid, output operation, output pixel_value, input ready);
    modport sink   (input valid, input operation, input pixel_value, output ready);
endinterface

// File: rtl/srem_out_if.sv
// ----------------------------------------------------------------------------
// srem_out_if
// Output channel: edge magnitude transactions with valid/ready handshake.
// ----------------------------------------------------------------------------
interface srem_out_if;
    logic                         valid;
    logic                         ready;
    logic [srem_pkg::PIX_W-1:0]   edge_value;
    logic                         row_end;
    logic                         frame_end;
    logic                         last_in_step;

    modport source (output valid, output edge_value, output row_end, output frame_end,
                    output last_in_step, input ready);
    modport sink   (input valid, input edge_value, input row_end, input frame_end,
                    input last_in_step, output ready);
endinterface

// File: rtl/sobel_roberts_edge_magnitude.sv
// ----------------------------------------------------------------------------
// sobel_roberts_edge_magnitude
// Streaming 3x3 Sobel / Roberts cross gradient magnitude with reflected borders.
// ----------------------------------------------------------------------------
// channel  | dir | handshake    | payload
// i_pix    | in  | valid/ready  | operation, pixel_value
// o_edge   | out | valid/ready  | edge_value, row_end, frame_end, last_in_step
// i_cfg_*  | in  | write enable | i_cfg_index, i_cfg_wdata
//
// one transaction per clock is accepted while i_pix.ready is high; its results pass
// the stage register beside the line store read and the result queue before output
// i_pix.ready drops only while the eight-entry result queue could overflow
// synchronous reset clears counters and the queue; the line stores are not cleared
// ----------------------------------------------------------------------------
module sobel_roberts_edge_magnitude (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [srem_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [srem_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    srem_in_if.sink                              i_pix,
    srem_out_if.source                           o_edge
);

    localparam int AW = srem_pkg::ADDR_W;

    // configuration
    logic [srem_pkg::COL_W-1:0] r_frame_width;
    logic [srem_pkg::ROW_W-1:0] r_frame_height;
    logic                       r_operator_select;

    // position state
    logic [srem_pkg::COL_W-1:0] r_col_cnt;
    logic [srem_pkg::ROW_W-1:0] r_row_cnt;
    logic [srem_pkg::COL_W-1:0] r_drain_cnt;
    logic                       r_draining;

    // stage 1
    srem_pkg::t_stage1          r_s1;
    srem_pkg::t_stage1          n_s1;
    logic [srem_pkg::PIX_W-1:0] r_s1_pix;
    logic [srem_pkg::PIX_W-1:0] r_win_cols [6];
    logic [srem_pkg::PIX_W-1:0] r_dsave_u;
    logic [srem_pkg::PIX_W-1:0] r_dsave_m;
    logic [2*srem_pkg::PIX_W-1:0] r_fwd;
    logic                       r_hit_a;
    logic                       r_hit_b;

    // stage 0 decode
    logic [AW-1:0]              wm1;
    logic [srem_pkg::COL_W-1:0] wm1_ext;
    logic [srem_pkg::ROW_W-1:0] hm1;
    logic [AW-1:0]              cur_c;
    logic [srem_pkg::ROW_W-1:0] cur_r;
    logic [AW-1:0]              cur_k;
    logic                       k_last;
    logic [AW-1:0]              addr_a;
    logic [AW-1:0]              addr_b;
    logic                       is_pixel_item;
    logic                       is_drain_item;
    logic                       accept;
    logic [srem_pkg::FIFO_CNT_W:0] room_need;
    logic [srem_pkg::FIFO_CNT_W-1:0] fifo_count;

    // stage 1 datapath
    logic [2*srem_pkg::PIX_W-1:0] rdata_a;
    logic [2*srem_pkg::PIX_W-1:0] rdata_b;
    logic [2*srem_pkg::PIX_W-1:0] da;
    logic [2*srem_pkg::PIX_W-1:0] db;
    logic [2*srem_pkg::PIX_W-1:0] wdata;
    srem_pkg::t_column          cur;
    srem_pkg::t_column          prev;
    srem_pkg::t_column          prev2;
    srem_pkg::t_column          col_a;
    srem_pkg::t_column          col_b;
    srem_pkg::t_column          col_s;
    srem_pkg::t_window          win_a;
    srem_pkg::t_window          win_b;
    srem_pkg::t_window          win_d;
    srem_pkg::t_window          win0;
    logic [srem_pkg::PIX_W-1:0] mag0;
    logic [srem_pkg::PIX_W-1:0] mag1;
    srem_pkg::t_result          res0;
    srem_pkg::t_result          res1;

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width     <= srem_pkg::FRAME_WIDTH_RST;
            r_frame_height    <= srem_pkg::FRAME_HEIGHT_RST;
            r_operator_select <= srem_pkg::OPSEL_SOBEL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                srem_pkg::CFG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_wdata[srem_pkg::COL_W-1:0];
                end
                srem_pkg::CFG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_wdata[srem_pkg::ROW_W-1:0];
                end
                srem_pkg::CFG_OPERATOR_SELECT: begin
                    r_operator_select <= i_cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    // stage 0: position decode and line store addressing
    always_comb begin
        if (r_frame_width == '0) begin
            wm1 = '0;
        end else if (r_frame_width > srem_pkg::COL_W'(srem_pkg::MAX_WIDTH)) begin
            wm1 = AW'(srem_pkg::MAX_WIDTH - 1);
        end else begin
            wm1 = AW'(r_frame_width - 1'b1);
        end
        wm1_ext = srem_pkg::COL_W'(wm1);
        hm1     = (r_frame_height == '0) ? '0 : r_frame_height - 1'b1;

        cur_c  = (r_col_cnt < wm1_ext) ? AW'(r_col_cnt) : wm1;
        cur_r  = (r_row_cnt < hm1) ? r_row_cnt : hm1;
        cur_k  = (r_drain_cnt < wm1_ext) ? AW'(r_drain_cnt) : wm1;
        k_last = (cur_k == wm1);

        addr_a = r_draining ? cur_k : cur_c;
        if (k_last) begin
            addr_b = (cur_k == '0) ? '0 : cur_k - 1'b1;
        end else begin
            addr_b = cur_k + 1'b1;
        end

        is_pixel_item = !r_draining && (i_pix.operation == srem_pkg::OP_PIXEL);
        is_drain_item = r_draining && (i_pix.operation == srem_pkg::OP_FLUSH);

        room_need   = (srem_pkg::FIFO_CNT_W+1)'(fifo_count)
                    + (srem_pkg::FIFO_CNT_W+1)'(r_s1.cnt) + 2'd2;
        i_pix.ready = (room_need <= (srem_pkg::FIFO_CNT_W+1)'(srem_pkg::FIFO_DEPTH));
        accept      = i_pix.valid && i_pix.ready;

        n_s1.pixel      = accept && is_pixel_item;
        n_s1.drain      = accept && is_drain_item;
        n_s1.addr       = cur_c;
        n_s1.top_is_mid = r_draining ? (hm1 == '0) : (cur_r == 16'd1);
        n_s1.en_a       = (cur_r != '0) && (cur_c != '0);
        n_s1.en_b       = (cur_r != '0) && (cur_c == wm1);
        n_s1.c_is1      = (cur_c == AW'(1));
        n_s1.c_ge1      = (cur_c != '0);
        n_s1.k0         = (cur_k == '0);
        n_s1.k_last     = k_last;
        if (n_s1.drain) begin
            n_s1.cnt = 2'd1;
        end else if (n_s1.pixel) begin
            n_s1.cnt = {1'b0, n_s1.en_a} + {1'b0, n_s1.en_b};
        end else begin
            n_s1.cnt = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt   <= '0;
            r_row_cnt   <= '0;
            r_drain_cnt <= '0;
            r_draining  <= 1'b0;
        end else if (accept && is_pixel_item) begin
            if (cur_c == wm1) begin
                r_col_cnt <= '0;
                if (cur_r == hm1) begin
                    r_draining  <= 1'b1;
                    r_drain_cnt <= '0;
                    r_row_cnt   <= cur_r;
                end else begin
                    r_row_cnt <= cur_r + 1'b1;
                end
            end else begin
                r_col_cnt <= srem_pkg::COL_W'(cur_c) + 1'b1;
            end
        end else if (accept && is_drain_item) begin
            if (k_last) begin
                r_draining  <= 1'b0;
                r_drain_cnt <= '0;
                r_row_cnt   <= '0;
                r_col_cnt   <= '0;
            end else begin
                r_drain_cnt <= srem_pkg::COL_W'(cur_k) + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1    <= '0;
            r_hit_a <= 1'b0;
            r_hit_b <= 1'b0;
        end else begin
            r_s1    <= n_s1;
            r_hit_a <= r_s1.pixel && (r_s1.addr == addr_a);
            r_hit_b <= r_s1.pixel && (r_s1.addr == addr_b);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_pix <= i_pix.pixel_value;
        r_fwd    <= wdata;
    end

    // line stores: upper row in the high byte, middle row in the low byte
    srem_line_ram #(
        .DEPTH (srem_pkg::MAX_WIDTH),
        .WIDTH (2 * srem_pkg::PIX_W)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_we      (r_s1.pixel),
        .i_waddr   (r_s1.addr),
        .i_wdata   (wdata),
        .i_raddr_a (addr_a),
        .i_raddr_b (addr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    // stage 1: window assembly
    always_comb begin
        da    = r_hit_a ? r_fwd : rdata_a;
        db    = r_hit_b ? r_fwd : rdata_b;
        wdata = {da[srem_pkg::PIX_W-1:0], r_s1_pix};

        cur   = srem_pkg::col_fill(da[2*srem_pkg::PIX_W-1:srem_pkg::PIX_W],
                                   da[srem_pkg::PIX_W-1:0], r_s1_pix, r_s1.top_is_mid);
        prev  = srem_pkg::col_fill(r_win_cols[0], r_win_cols[1], r_win_cols[2],
                                   r_s1.top_is_mid);
        prev2 = srem_pkg::col_fill(r_win_cols[3], r_win_cols[4], r_win_cols[5],
                                   r_s1.top_is_mid);

        win_a.left   = r_s1.c_is1 ? prev : prev2;
        win_a.center = prev;
        win_a.right  = cur;
        win_b.left   = r_s1.c_ge1 ? prev : cur;
        win_b.center = cur;
        win_b.right  = cur;

        col_a = srem_pkg::col_fill(da[2*srem_pkg::PIX_W-1:srem_pkg::PIX_W],
                                   da[srem_pkg::PIX_W-1:0], da[srem_pkg::PIX_W-1:0],
                                   r_s1.top_is_mid);
        col_b = srem_pkg::col_fill(db[2*srem_pkg::PIX_W-1:srem_pkg::PIX_W],
                                   db[srem_pkg::PIX_W-1:0], db[srem_pkg::PIX_W-1:0],
                                   r_s1.top_is_mid);
        col_s = srem_pkg::col_fill(r_dsave_u, r_dsave_m, r_dsave_m, r_s1.top_is_mid);

        if (r_s1.k_last) begin
            win_d.left = col_b;
        end else if (r_s1.k0) begin
            win_d.left = col_a;
        end else begin
            win_d.left = col_s;
        end
        win_d.center = col_a;
        win_d.right  = r_s1.k_last ? col_a : col_b;

        win0 = r_s1.drain ? win_d : win_a;
    end

    always_ff @(posedge i_clk) begin
        if (r_s1.pixel) begin
            r_win_cols[3] <= r_win_cols[0];
            r_win_cols[4] <= r_win_cols[1];
            r_win_cols[5] <= r_win_cols[2];
            r_win_cols[0] <= da[2*srem_pkg::PIX_W-1:srem_pkg::PIX_W];
            r_win_cols[1] <= da[srem_pkg::PIX_W-1:0];
            r_win_cols[2] <= r_s1_pix;
        end
        if (r_s1.drain) begin
            r_dsave_u <= da[2*srem_pkg::PIX_W-1:srem_pkg::PIX_W];
            r_dsave_m <= da[srem_pkg::PIX_W-1:0];
        end
    end

    srem_kernel u_kernel0 (
        .i_window (win0),
        .i_opsel  (r_operator_select),
        .o_mag    (mag0)
    );

    srem_kernel u_kernel1 (
        .i_window (win_b),
        .i_opsel  (r_operator_select),
        .o_mag    (mag1)
    );

    always_comb begin
        res0.edge_value   = (r_s1.pixel && !r_s1.en_a) ? mag1 : mag0;
        res0.row_end      = r_s1.drain ? r_s1.k_last : !r_s1.en_a;
        res0.frame_end    = r_s1.drain && r_s1.k_last;
        res0.last_in_step = (r_s1.cnt == 2'd1);

        res1.edge_value   = mag1;
        res1.row_end      = 1'b1;
        res1.frame_end    = 1'b0;
        res1.last_in_step = 1'b1;
    end

    srem_out_fifo u_out_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (r_s1.cnt),
        .i_data0    (res0),
        .i_data1    (res1),
        .o_count    (fifo_count),
        .o_edge     (o_edge)
    );

endmodule

// File: rtl/srem_line_ram.sv
// ----------------------------------------------------------------------------
// srem_line_ram
// Line store RAM: one write port, two registered read ports, read-first.
// ----------------------------------------------------------------------------
module srem_line_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// File: rtl/srem_kernel.sv
// ----------------------------------------------------------------------------
// srem_kernel
// Sobel or Roberts cross correlation of a 3x3 window, |gx|+|gy| saturated.
// ----------------------------------------------------------------------------
module srem_kernel (
    input  srem_pkg::t_window           i_window,
    input  logic                        i_opsel,
    output logic [srem_pkg::PIX_W-1:0]  o_mag
);

    logic [9:0]         s_top;
    logic [9:0]         s_bot;
    logic [9:0]         s_left;
    logic [9:0]         s_right;
    logic signed [11:0] gx;
    logic signed [11:0] gy;
    logic [10:0]        ax;
    logic [10:0]        ay;
    logic [11:0]        sum;

    always_comb begin
        s_top   = {2'b00, i_window.left.top} + {1'b0, i_window.center.top, 1'b0}
                + {2'b00, i_window.right.top};
        s_bot   = {2'b00, i_window.left.bot} + {1'b0, i_window.center.bot, 1'b0}
                + {2'b00, i_window.right.bot};
        s_left  = {2'b00, i_window.left.top} + {1'b0, i_window.left.mid, 1'b0}
                + {2'b00, i_window.left.bot};
        s_right = {2'b00, i_window.right.top} + {1'b0, i_window.right.mid, 1'b0}
                + {2'b00, i_window.right.bot};

        if (i_opsel == srem_pkg::OPSEL_ROBERTS) begin
            gx = $signed({4'b0000, i_window.right.bot}) - $signed({4'b0000, i_window.center.mid});
            gy = $signed({4'b0000, i_window.center.bot}) - $signed({4'b0000, i_window.right.mid});
        end else begin
            gx = $signed({2'b00, s_bot}) - $signed({2'b00, s_top});
            gy = $signed({2'b00, s_right}) - $signed({2'b00, s_left});
        end

        ax  = gx[11] ? 11'(-gx) : 11'(gx);
        ay  = gy[11] ? 11'(-gy) : 11'(gy);
        sum = {1'b0, ax} + {1'b0, ay};

        o_mag = (sum > 12'd255) ? 8'hFF : sum[7:0];
    end

endmodule

// File: rtl/srem_out_fifo.sv
// ----------------------------------------------------------------------------
// srem_out_fifo
// Result queue: takes up to two results a cycle, hands out one a cycle while o_edge.ready is high.
// ----------------------------------------------------------------------------
module srem_out_fifo (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [1:0]                          i_push_cnt,
    input  srem_pkg::t_result                   i_data0,
    input  srem_pkg::t_result                   i_data1,
    output logic [srem_pkg::FIFO_CNT_W-1:0]     o_count,
    srem_out_if.source                          o_edge
);

    srem_pkg::t_result                    r_mem [srem_pkg::FIFO_DEPTH];
    logic [srem_pkg::FIFO_PTR_W-1:0]      r_wr_ptr;
    logic [srem_pkg::FIFO_PTR_W-1:0]      r_rd_ptr;
    logic [srem_pkg::FIFO_CNT_W-1:0]      r_count;
    logic [srem_pkg::FIFO_PTR_W-1:0]      n_wr_ptr;
    logic [srem_pkg::FIFO_PTR_W-1:0]      n_rd_ptr;
    logic [srem_pkg::FIFO_CNT_W-1:0]      n_count;
    logic [srem_pkg::FIFO_PTR_W-1:0]      wr_ptr1;
    logic                                 pop;
    srem_pkg::t_result                    head;

    always_comb begin
        pop      = o_edge.valid && o_edge.ready;
        wr_ptr1  = r_wr_ptr + 1'b1;
        n_wr_ptr = r_wr_ptr + srem_pkg::FIFO_PTR_W'(i_push_cnt);
        n_rd_ptr = r_rd_ptr + srem_pkg::FIFO_PTR_W'(pop);
        n_count  = r_count + srem_pkg::FIFO_CNT_W'(i_push_cnt)
                 - srem_pkg::FIFO_CNT_W'(pop);
        head     = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_data0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[wr_ptr1] <= i_data1;
        end
    end

    assign o_count             = r_count;
    assign o_edge.valid        = (r_count != '0);
    assign o_edge.edge_value   = head.edge_value;
    assign o_edge.row_end      = head.row_end;
    assign o_edge.frame_end    = head.frame_end;
    assign o_edge.last_in_step = head.last_in_step;

endmodule

// File: rtl/srem_checker.sv
// ----------------------------------------------------------------------------
// srem_checker
// Port-level checks of the edge magnitude output channel, bound to the top.
// ----------------------------------------------------------------------------
module srem_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [srem_pkg::PIX_W-1:0]  i_edge_value,
    input logic                        i_row_end,
    input logic                        i_frame_end,
    input logic                        i_last_in_step
);

    // stalled transaction stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output transaction dropped while stalled");

    // stalled payload is stable
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_edge_value) && $stable(i_row_end) && $stable(i_frame_end)
            && $stable(i_last_in_step))
        else $error("output payload changed while stalled");

    // reset empties the result queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // frame end closes a row and the step that caused it
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_frame_end |-> i_row_end && i_last_in_step)
        else $error("frame end without row end or last in step");

endmodule

bind sobel_roberts_edge_magnitude srem_checker u_srem_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_edge.valid),
    .i_out_ready    (o_edge.ready),
    .i_edge_value   (o_edge.edge_value),
    .i_row_end      (o_edge.row_end),
    .i_frame_end    (o_edge.frame_end),
    .i_last_in_step (o_edge.last_in_step)
);

// File: verif/sobel_roberts_edge_magnitude_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_roberts_edge_magnitude_tb
// Streams grayscale frames into the edge filter and compares every edge
// transaction with a cycle-free model of the line stores, the 3x3 window and
// the Sobel / Roberts gradient. Covers reflected borders, one-pixel frames,
// ignored flushes and pixels, width and height clamping, register changes in
// the middle of a frame, and random stalls on both channels.
// ----------------------------------------------------------------------------
module sobel_roberts_edge_magnitude_tb;
    import srem_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int RANDOM_ITEMS  = 900;
    localparam int SETTLE_CYCLES = 6;
    localparam int TAIL_CYCLES   = 20;
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int MAX_REPORTS   = 40;

    class edge_ledger;
        logic [COL_W-1:0] width_reg;
        logic [ROW_W-1:0] height_reg;
        logic             opsel;
        logic [PIX_W-1:0] upper_row  [MAX_WIDTH];
        logic [PIX_W-1:0] middle_row [MAX_WIDTH];
        t_column          col_prev;
        t_column          col_prev2;
        int               col_cnt;
        int               row_cnt;
        int               drain_cnt;
        bit               draining;
        t_result          edges_due[$];
        int               errors;

        function new();
            width_reg  = FRAME_WIDTH_RST;
            height_reg = FRAME_HEIGHT_RST;
            opsel      = OPSEL_SOBEL;
            foreach (upper_row[i]) begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            col_prev  = '0;
            col_prev2 = '0;
            col_cnt   = 0;
            row_cnt   = 0;
            drain_cnt = 0;
            draining  = 1'b0;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_FRAME_WIDTH:     width_reg  = data[COL_W-1:0];
                CFG_FRAME_HEIGHT:    height_reg = data[ROW_W-1:0];
                CFG_OPERATOR_SELECT: opsel      = data[0];
                default: ;
            endcase
        endfunction

        function int active_width();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_WIDTH) return MAX_WIDTH;
            return int'(width_reg);
        endfunction

        function int active_height();
            return (height_reg == 0) ? 1 : int'(height_reg);
        endfunction

        // reflected top border: the row above row 0 repeats row 0
        function t_column column_of(t_column raw, bit top_is_mid);
            t_column col;
            col = raw;
            if (top_is_mid) col.top = raw.mid;
            return col;
        endfunction

        function logic [PIX_W-1:0] gradient(t_column l, t_column c, t_column r);
            int gx;
            int gy;
            if (opsel == OPSEL_SOBEL) begin
                gx = int'(l.bot) + 2 * int'(c.bot) + int'(r.bot)
                   - int'(l.top) - 2 * int'(c.top) - int'(r.top);
                gy = int'(r.top) + 2 * int'(r.mid) + int'(r.bot)
                   - int'(l.top) - 2 * int'(l.mid) - int'(l.bot);
            end else begin
                gx = int'(r.bot) - int'(c.mid);
                gy = int'(c.bot) - int'(r.mid);
            end
            if (gx < 0) gx = -gx;
            if (gy < 0) gy = -gy;
            gx = gx + gy;
            return (gx > 255) ? 8'd255 : PIX_W'(gx);
        endfunction

        function void push_edge(logic [PIX_W-1:0] val, bit re, bit fe, bit is_last);
            t_result res;
            res.edge_value   = val;
            res.row_end      = re;
            res.frame_end    = fe;
            res.last_in_step = is_last;
            edges_due.push_back(res);
        endfunction

        // returns 0 when the block ignores the transaction
        function bit accept_item(logic op, logic [PIX_W-1:0] pix);
            int               w;
            int               h;
            int               k;
            int               c;
            int               r;
            int               jl;
            int               jr;
            logic [PIX_W-1:0] u;
            logic [PIX_W-1:0] m;
            bit               top_is_mid;
            t_column          cur;
            t_column          prv;
            t_column          prv2;
            w = active_width();
            h = active_height();
            if (draining) begin
                if (op == OP_PIXEL) return 1'b0;
                k  = (drain_cnt < w - 1) ? drain_cnt : w - 1;
                jl = (k == 0) ? 0 : k - 1;
                jr = (k + 1 >= w) ? w - 1 : k + 1;
                top_is_mid = (h < 2);
                push_edge(gradient(column_of({upper_row[jl], middle_row[jl], middle_row[jl]},
                                             top_is_mid),
                                   column_of({upper_row[k], middle_row[k], middle_row[k]},
                                             top_is_mid),
                                   column_of({upper_row[jr], middle_row[jr], middle_row[jr]},
                                             top_is_mid)),
                          k == w - 1, k == w - 1, 1'b1);
                if (k >= w - 1) begin
                    draining  = 1'b0;
                    drain_cnt = 0;
                    row_cnt   = 0;
                    col_cnt   = 0;
                end else begin
                    drain_cnt = k + 1;
                end
                return 1'b1;
            end
            if (op == OP_FLUSH) return 1'b0;
            c = (col_cnt < w - 1) ? col_cnt : w - 1;
            r = (row_cnt < h - 1) ? row_cnt : h - 1;
            u = upper_row[c];
            m = middle_row[c];
            top_is_mid    = (r == 1);
            upper_row[c]  = m;
            middle_row[c] = pix;
            cur  = column_of({u, m, pix}, top_is_mid);
            prv  = column_of(col_prev, top_is_mid);
            prv2 = column_of(col_prev2, top_is_mid);
            if (r >= 1) begin
                if (c >= 1)
                    push_edge(gradient((c == 1) ? prv : prv2, prv, cur), 1'b0, 1'b0, c != w - 1);
                if (c == w - 1)
                    push_edge(gradient((c >= 1) ? prv : cur, cur, cur), 1'b1, 1'b0, 1'b1);
            end
            col_prev2 = col_prev;
            col_prev  = {u, m, pix};
            if (c >= w - 1) begin
                col_cnt = 0;
                if (r >= h - 1) begin
                    draining  = 1'b1;
                    drain_cnt = 0;
                    row_cnt   = r;
                end else begin
                    row_cnt = r + 1;
                end
            end else begin
                col_cnt = c + 1;
            end
            return 1'b1;
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            end
        endfunction

        function void check_edge(t_result got);
            t_result want;
            if (edges_due.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $error("edge transaction with nothing expected: edge_value %0d",
                           got.edge_value);
                return;
            end
            want = edges_due.pop_front();
            compare_field("edge_value", want.edge_value, got.edge_value);
            compare_field("row_end", want.row_end, got.row_end);
            compare_field("frame_end", want.frame_end, got.frame_end);
            compare_field("last_in_step", want.last_in_step, got.last_in_step);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    srem_in_if  pix_if();
    srem_out_if edge_if();

    edge_ledger ledger;
    bit         no_idle;
    int         stall_left;
    int         taken_items;
    int         cycle_count;

    sobel_roberts_edge_magnitude u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pix       (pix_if),
        .o_edge      (edge_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int idle_length();
        int roll;
        roll = $urandom_range(99);
        if (roll < 75) return $urandom_range(3, 1);
        if (roll < 95) return $urandom_range(10, 4);
        return $urandom_range(40, 20);
    endfunction

    function automatic int rand_width();
        int roll;
        roll = $urandom_range(99);
        if (roll < 75) return $urandom_range(8, 1);
        if (roll < 95) return $urandom_range(32, 9);
        return $urandom_range(100, 33);
    endfunction

    function automatic int rand_height();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70) return $urandom_range(4, 1);
        if (roll < 95) return $urandom_range(10, 5);
        return $urandom_range(20, 11);
    endfunction

    // unused upper bits of the narrow registers carry random junk
    function automatic logic [CFG_DATA_W-1:0] reg_word(logic [CFG_IDX_W-1:0] idx, int value);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'(value);
        if (idx == CFG_FRAME_WIDTH)
            data = {5'($urandom_range(31)), data[COL_W-1:0]};
        else if (idx == CFG_OPERATOR_SELECT)
            data = {15'($urandom_range(32767)), data[0]};
        return data;
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        ledger.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic program_frame(input int w, input int h, input logic op);
        cfg_write(CFG_FRAME_WIDTH, reg_word(CFG_FRAME_WIDTH, w));
        cfg_write(CFG_FRAME_HEIGHT, reg_word(CFG_FRAME_HEIGHT, h));
        cfg_write(CFG_OPERATOR_SELECT, reg_word(CFG_OPERATOR_SELECT, op));
    endtask

    task automatic settle();
        pix_if.valid <= 1'b0;
        while (ledger.edges_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic send_item(input logic op, input logic [PIX_W-1:0] pix);
        int gap;
        pix_if.valid       <= 1'b1;
        pix_if.operation   <= op;
        pix_if.pixel_value <= pix;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        if (ledger.accept_item(op, pix)) taken_items++;
        @(negedge i_clk);
        gap = (!no_idle && $urandom_range(99) < 35) ? idle_length() : 0;
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic stream_frame(input bit noisy, input int change_at,
                                input logic [CFG_IDX_W-1:0] change_idx,
                                input logic [CFG_DATA_W-1:0] change_data);
        int sent;
        sent = 0;
        while (!ledger.draining) begin
            if (sent == change_at) begin
                settle();
                cfg_write(change_idx, change_data);
            end
            if (noisy && $urandom_range(99) < 3) begin
                send_item(OP_FLUSH, PIX_W'($urandom));
            end else begin
                send_item(OP_PIXEL, PIX_W'($urandom));
                sent++;
            end
        end
        while (ledger.draining) begin
            if (noisy && $urandom_range(99) < 3)
                send_item(OP_PIXEL, PIX_W'($urandom));
            else
                send_item(OP_FLUSH, PIX_W'($urandom));
        end
    endtask

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            edge_if.ready <= 1'b0;
            stall_left--;
        end else if (!no_idle && $urandom_range(99) < 25) begin
            edge_if.ready <= 1'b0;
            stall_left = idle_length() - 1;
        end else begin
            edge_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && edge_if.valid && edge_if.ready) begin
            got.edge_value   = edge_if.edge_value;
            got.row_end      = edge_if.row_end;
            got.frame_end    = edge_if.frame_end;
            got.last_in_step = edge_if.last_in_step;
            ledger.check_edge(got);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int                    i;
        int                    change_at;
        logic [CFG_IDX_W-1:0]  change_idx;
        int                    change_val;
        ledger             = new();
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = '0;
        i_cfg_wdata        = '0;
        pix_if.valid       = 1'b0;
        pix_if.operation   = OP_PIXEL;
        pix_if.pixel_value = '0;
        edge_if.ready      = 1'b0;
        no_idle            = 1'b0;
        stall_left         = 0;
        taken_items        = 0;
        cycle_count        = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // 3x3 checkerboard at full contrast, early flush, pixel while draining
        program_frame(3, 3, OPSEL_SOBEL);
        cfg_write(CFG_SPARE, 16'hA5C3);
        send_item(OP_FLUSH, 8'hFF);
        for (i = 0; i < 9; i++) send_item(OP_PIXEL, (i % 2) ? 8'hFF : 8'h00);
        send_item(OP_PIXEL, 8'hFF);
        repeat (3) send_item(OP_FLUSH, 8'h00);
        settle();

        // single pixel frames, zero width and height clamp to one; then a 2x2 Roberts frame
        program_frame(1, 1, OPSEL_ROBERTS);
        send_item(OP_PIXEL, 8'hFF);
        send_item(OP_FLUSH, 8'h55);
        settle();
        program_frame(0, 0, OPSEL_ROBERTS);
        send_item(OP_PIXEL, 8'h80);
        send_item(OP_FLUSH, 8'hAA);
        settle();
        program_frame(2, 2, OPSEL_ROBERTS);
        send_item(OP_PIXEL, 8'hFF);
        send_item(OP_PIXEL, 8'h00);
        send_item(OP_PIXEL, 8'h00);
        send_item(OP_PIXEL, 8'hFF);
        repeat (2) send_item(OP_FLUSH, 8'h00);
        settle();

        // width above max clamps until cut to the widest random width mid-row;
        // fills every line store entry that later frames can reach
        program_frame(2047, 2, OPSEL_SOBEL);
        stream_frame(1'b0, 40, CFG_FRAME_WIDTH, reg_word(CFG_FRAME_WIDTH, 100));
        settle();

        // tallest frame, cut short by lowering the height mid-frame
        program_frame(2, 65535, OPSEL_SOBEL);
        stream_frame(1'b0, 20, CFG_FRAME_HEIGHT, reg_word(CFG_FRAME_HEIGHT, 12));

        taken_items = 0;
        while (taken_items < RANDOM_ITEMS) begin
            if ($urandom_range(99) < 60) begin
                settle();
                program_frame(rand_width(), rand_height(), logic'($urandom_range(1)));
            end
            no_idle    = ($urandom_range(99) < 20);
            change_at  = ($urandom_range(99) < 15) ? $urandom_range(30) : -1;
            change_idx = CFG_IDX_W'($urandom_range(2));
            if (change_idx == CFG_FRAME_WIDTH)
                change_val = rand_width();
            else if (change_idx == CFG_FRAME_HEIGHT)
                change_val = rand_height();
            else
                change_val = $urandom_range(1);
            stream_frame(1'b1, change_at, change_idx, reg_word(change_idx, change_val));
        end

        no_idle = 1'b0;
        settle();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (ledger.errors == 0 && ledger.edges_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// File: sim.f
rtl/srem_pkg.sv
rtl/srem_in_if.sv
rtl/srem_out_if.sv
rtl/srem_line_ram.sv
rtl/srem_kernel.sv
rtl/srem_out_fifo.sv
rtl/sobel_roberts_edge_magnitude.sv
rtl/srem_checker.sv
verif/sobel_roberts_edge_magnitude_tb.sv
